// File: hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked assertion shorthands used by the ray and wall hit logic.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: hw/rtl/rwnh_pkg.sv
// ============================================================================
// Ray and wall hit package
// Widths, defaults and shared types of the nearest-hit block.
// ============================================================================
package rwnh_pkg;

    localparam int DIR_W         = 19;
    localparam int PT_W          = 24;
    localparam int DIST_W        = 26;
    localparam int TAG_W         = 8;
    localparam int PROD_W        = 43;
    localparam int DIVR_W        = 19;
    localparam int RAD_W         = 50;
    localparam int ROOT_W        = 25;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LIMIT_BASE    = 1000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: hw/rtl/rwnh_div.sv
// ============================================================================
// Restoring divider
// Unsigned divider producing one quotient bit per cycle.
// ============================================================================
module rwnh_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rwnh_pkg::PROD_W-1:0] dividend,
    input  logic [rwnh_pkg::DIVR_W-1:0] divisor,
    output logic [rwnh_pkg::PROD_W-1:0] quotient,
    output rwnh_pkg::unit_stat_t        stat
);
    import rwnh_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVR_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(PROD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DIVR_W'(rem_sh - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_reg <= rem_sh[DIVR_W-1:0];
                end
                quo_reg <= {quo_reg[PROD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hw/rtl/rwnh_sqrt.sv
// ============================================================================
// Integer square root
// Floor square root producing one root bit per cycle.
// ============================================================================
module rwnh_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rwnh_pkg::RAD_W-1:0]  radicand,
    output logic [rwnh_pkg::ROOT_W-1:0] root,
    output rwnh_pkg::unit_stat_t        stat
);
    import rwnh_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: hw/rtl/ray_axis_wall_nearest_hit.sv
// ============================================================================
// Ray against axis-aligned walls, nearest hit
// Tests one ray and wall pair per input beat and reports the nearest hit.
// ============================================================================
// Each input beat carries one ray and one wall; the block keeps the nearest
// hit and sends one result beat when the beat marked last has been processed.
// A wall that is missed or met head-on skips the arithmetic units; a general
// crossing runs the bit-serial divider (43 steps) and, if the crossing lies
// on the wall, the bit-serial square root (25 steps), one after the other.
// The beat marked last then loads the output register once it is free.
`include "assert_macros.svh"

module ray_axis_wall_nearest_hit #(
    parameter int FRAC_BITS = rwnh_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ray_x, ray_y, origin_x, origin_y, wall_x1, wall_y1, wall_x2, wall_y2,
    // wall_tag, two zero bits
    input  logic [191:0] s_axis_tdata,
    // wall_kind
    input  logic         s_axis_tuser,
    // last_wall
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_x, hit_y, hit_distance, hit_wall_tag, six zero bits
    output logic [87:0]  m_axis_tdata,
    // hit_found
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [25:0]  cfg_data
);
    import rwnh_pkg::*;

    localparam logic [DIST_W-1:0] LIMIT_RESET =
        DIST_W'(64'(LIMIT_BASE) << FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_CROSS, ST_SQ_A, ST_SQ_B,
        ST_SQRT_GO, ST_SQRT_WAIT, ST_UPDATE, ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic signed [DIR_W-1:0]  ra_reg, rb_reg;
    logic signed [PT_W-1:0]   oa_reg, ob_reg, a1_reg, a2_reg, b1_reg, b2_reg;
    logic                     kind_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic                     last_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic signed [PT_W:0]     db_reg;
    logic [RAD_W-1:0]         sq_reg, sum_reg;
    logic                     hit_reg;
    logic signed [PT_W-1:0]   hit_b_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic                     div_start_reg, sqrt_start_reg;
    logic [DIST_W-1:0]        limit_reg, best_dist_reg;
    logic signed [PT_W-1:0]   best_x_reg, best_y_reg;
    logic [TAG_W-1:0]         best_tag_reg;
    logic                     best_valid_reg;
    logic                     out_valid_reg, out_found_reg;
    logic [PT_W-1:0]          out_x_reg, out_y_reg;
    logic [DIST_W-1:0]        out_dist_reg;
    logic [TAG_W-1:0]         out_tag_reg;

    logic signed [PT_W:0]     da;
    logic [PT_W:0]            da_mag;
    logic [DIVR_W-1:0]        ra_mag;
    logic signed [25:0]       mul_a, mul_b;
    logic signed [51:0]       mul_p;
    logic [51:0]              mul_mag;
    logic [PROD_W-1:0]        quo;
    logic [ROOT_W-1:0]        root;
    unit_stat_t               div_stat, sqrt_stat;
    logic signed [PROD_W+1:0] q_s, cb;
    logic                     cb_in;
    logic                     in_go, out_free;

    assign da      = PT_W'(0) + ($signed({a1_reg[PT_W-1], a1_reg}) -
                                 $signed({oa_reg[PT_W-1], oa_reg}));
    assign da_mag  = da[PT_W] ? (PT_W+1)'(-da) : (PT_W+1)'(da);
    assign ra_mag  = ra_reg[DIR_W-1] ? DIVR_W'(-ra_reg) : DIVR_W'(ra_reg);

    always_comb
    begin
        case (state_reg)
            ST_SQ_A:
            begin
                mul_a = 26'(da);
                mul_b = 26'(da);
            end
            ST_SQ_B:
            begin
                mul_a = 26'(db_reg);
                mul_b = 26'(db_reg);
            end
            default:
            begin
                mul_a = 26'(da);
                mul_b = 26'(rb_reg);
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_mag = mul_p[51] ? 52'(-mul_p) : 52'(mul_p);

    assign q_s   = $signed({2'b00, quo});
    assign cb    = (PROD_W+2)'(ob_reg) + (neg_reg ? -q_s : q_s);
    assign cb_in = (cb >= (PROD_W+2)'(b1_reg)) && (cb <= (PROD_W+2)'(b2_reg));

    assign in_go    = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    rwnh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (ra_mag),
        .quotient (quo),
        .stat     (div_stat)
    );

    rwnh_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sum_reg),
        .root     (root),
        .stat     (sqrt_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            best_dist_reg  <= LIMIT_RESET;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_tag_reg   <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_go)
                    begin
                        kind_reg <= s_axis_tuser;
                        tag_reg  <= s_axis_tdata[189:182];
                        last_reg <= s_axis_tlast;
                        if (s_axis_tuser)
                        begin
                            ra_reg <= s_axis_tdata[37:19];
                            rb_reg <= s_axis_tdata[18:0];
                            oa_reg <= s_axis_tdata[85:62];
                            ob_reg <= s_axis_tdata[61:38];
                            a1_reg <= s_axis_tdata[133:110];
                            a2_reg <= s_axis_tdata[181:158];
                            b1_reg <= s_axis_tdata[109:86];
                            b2_reg <= s_axis_tdata[157:134];
                        end
                        else
                        begin
                            ra_reg <= s_axis_tdata[18:0];
                            rb_reg <= s_axis_tdata[37:19];
                            oa_reg <= s_axis_tdata[61:38];
                            ob_reg <= s_axis_tdata[85:62];
                            a1_reg <= s_axis_tdata[109:86];
                            a2_reg <= s_axis_tdata[157:134];
                            b1_reg <= s_axis_tdata[133:110];
                            b2_reg <= s_axis_tdata[181:158];
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if ((ra_reg == '0) || (!ra_reg[DIR_W-1] && (a2_reg < oa_reg)) ||
                        (ra_reg[DIR_W-1] && (a1_reg > oa_reg)))
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_UPDATE;
                    end
                    else if (rb_reg == '0)
                    begin
                        hit_reg   <= (ob_reg >= b1_reg) && (ob_reg <= b2_reg);
                        hit_b_reg <= ob_reg;
                        dist_reg  <= DIST_W'(da_mag);
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        prod_reg  <= mul_mag[PROD_W-1:0];
                        neg_reg   <= mul_p[51] ^ ra_reg[DIR_W-1];
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_CROSS;
                    end
                end
                ST_CROSS:
                begin
                    hit_b_reg <= cb[PT_W-1:0];
                    db_reg    <= (PT_W+1)'(cb - (PROD_W+2)'(ob_reg));
                    if (cb_in)
                    begin
                        state_reg <= ST_SQ_A;
                    end
                    else
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_SQ_A:
                begin
                    sq_reg    <= mul_mag[RAD_W-1:0];
                    state_reg <= ST_SQ_B;
                end
                ST_SQ_B:
                begin
                    sum_reg   <= sq_reg + mul_mag[RAD_W-1:0];
                    state_reg <= ST_SQRT_GO;
                end
                ST_SQRT_GO:
                begin
                    sqrt_start_reg <= 1'b1;
                    state_reg      <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT:
                begin
                    if (sqrt_stat.done)
                    begin
                        dist_reg  <= DIST_W'(root);
                        hit_reg   <= 1'b1;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (hit_reg && (dist_reg < best_dist_reg))
                    begin
                        best_dist_reg  <= dist_reg;
                        best_x_reg     <= kind_reg ? hit_b_reg : a1_reg;
                        best_y_reg     <= kind_reg ? a1_reg : hit_b_reg;
                        best_tag_reg   <= tag_reg;
                        best_valid_reg <= 1'b1;
                    end
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_found_reg  <= best_valid_reg;
                        out_x_reg      <= best_valid_reg ? best_x_reg : '0;
                        out_y_reg      <= best_valid_reg ? best_y_reg : '0;
                        out_dist_reg   <= best_valid_reg ? best_dist_reg : '0;
                        out_tag_reg    <= best_valid_reg ? best_tag_reg : '0;
                        best_dist_reg  <= limit_reg;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        best_tag_reg   <= '0;
                        best_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
                if (!best_valid_reg)
                begin
                    best_dist_reg <= cfg_data;
                end
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {6'b0, out_tag_reg, out_dist_reg, out_y_reg, out_x_reg};

    `ASSERT_CLK(a_div_done_wait, div_stat.done |-> (state_reg == ST_DIV_WAIT), "stray done")
    `ASSERT_CLK(a_best_limit, !best_valid_reg |-> (best_dist_reg == limit_reg), "off limit")
    `ASSERT_NEVER(a_miss_zero, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata != '0), "miss data")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Nearest wall hit testbench
// Streams ray and wall pairs into the block under random gaps and stalls,
// predicts the nearest hit per ray in integer arithmetic and checks every
// result beat field by field. The distance limit is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rwnh_pkg::*;

    typedef struct {
        logic signed [18:0] ray_x, ray_y;
        logic signed [23:0] org_x, org_y, x1, y1, x2, y2;
        logic               kind;
        logic [7:0]         tag;
        logic               last;
    } wall_beat_t;

    typedef struct {
        logic               found;
        logic signed [23:0] hx, hy;
        logic [25:0]        distance;
        logic [7:0]         tag;
    } hit_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [25:0]  cfg_data = '0;

    wall_beat_t pending_beats[$];
    hit_t       expected_hits[$];
    int         errors = 0;
    int         hold_off = 0;
    int         send_wait = 0;
    int         recv_wait = 0;

    // Handshake state seen at the last rising edge.
    logic s_axis_tready_q = 1'b0;
    logic m_taken_q = 1'b0;

    logic [25:0]        lim = 26'(LIMIT_BASE << FRAC_BITS_DEF);
    logic [25:0]        best_dist;
    logic signed [23:0] best_x, best_y;
    logic [7:0]         best_tag;
    logic               best_ok;

    ray_axis_wall_nearest_hit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint isqrt64(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Across-axis a, along-axis b. Returns 1 on hit.
    function automatic bit cross_wall(longint ra, longint rb, longint oa, longint ob,
                                      longint a1, longint a2, longint b1, longint b2,
                                      output longint hb, output longint d);
        longint q, da, db;
        hb = 0;
        d = 0;
        if (ra == 0) return 0;
        if (ra > 0 && a2 < oa) return 0;
        if (ra < 0 && a1 > oa) return 0;
        if (rb == 0)
        begin
            if (ob < b1 || ob > b2) return 0;
            hb = ob;
            d = absl(oa - a1);
            return 1;
        end
        q = (absl(a1 - oa) * absl(rb)) / absl(ra);
        if (((a1 - oa < 0) != (rb < 0)) != (ra < 0)) q = -q;
        hb = ob + q;
        if (hb < b1 || hb > b2) return 0;
        da = a1 - oa;
        db = hb - ob;
        d = isqrt64(longint'(da * da + db * db));
        return 1;
    endfunction

    task automatic clear_nearest();
        best_dist = lim;
        best_x = '0;
        best_y = '0;
        best_tag = '0;
        best_ok = 1'b0;
    endtask

    task automatic predict_nearest(input wall_beat_t w);
        longint hb, d, hx, hy;
        bit hit;
        hit_t h;
        if (w.kind)
        begin
            hit = cross_wall(w.ray_y, w.ray_x, w.org_y, w.org_x, w.y1, w.y2, w.x1, w.x2,
                             hb, d);
            hx = hb;
            hy = w.y1;
        end
        else
        begin
            hit = cross_wall(w.ray_x, w.ray_y, w.org_x, w.org_y, w.x1, w.x2, w.y1, w.y2,
                             hb, d);
            hx = w.x1;
            hy = hb;
        end
        if (hit && d < longint'(best_dist))
        begin
            best_dist = 26'(d);
            best_x = 24'(hx);
            best_y = 24'(hy);
            best_tag = w.tag;
            best_ok = 1'b1;
        end
        if (w.last)
        begin
            h.found = best_ok;
            h.hx = best_ok ? best_x : '0;
            h.hy = best_ok ? best_y : '0;
            h.distance = best_ok ? best_dist : '0;
            h.tag = best_ok ? best_tag : '0;
            expected_hits.push_back(h);
            clear_nearest();
        end
    endtask

    always @(posedge clk)
    begin
        wall_beat_t w;
        if (s_axis_tvalid && s_axis_tready)
        begin
            w = pending_beats.pop_front();
            predict_nearest(w);
        end
    end

    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tready;
        m_taken_q <= m_axis_tvalid && m_axis_tready;
    end

    always @(negedge clk)
    begin
        wall_beat_t w;
        if (rst_n && !(s_axis_tvalid && !s_axis_tready_q))
        begin
            if (send_wait > 0)
            begin
                send_wait <= send_wait - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                w = pending_beats[0];
                s_axis_tdata <= {2'b00, w.tag, w.y2, w.x2, w.y1, w.x1, w.org_y, w.org_x,
                                 w.ray_y, w.ray_x};
                s_axis_tuser <= w.kind;
                s_axis_tlast <= w.last;
                s_axis_tvalid <= 1'b1;
                send_wait <= $urandom_range(0, 4);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        hit_t e;
        logic signed [23:0] ax, ay;
        if (m_axis_tvalid && m_axis_tready)
        begin
            ax = m_axis_tdata[23:0];
            ay = m_axis_tdata[47:24];
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (m_axis_tuser !== e.found)
                begin
                    $error("hit_found expected %0d actual %0d", e.found, m_axis_tuser);
                    errors++;
                end
                if (ax !== e.hx)
                begin
                    $error("hit_x expected %0d actual %0d", e.hx, ax);
                    errors++;
                end
                if (ay !== e.hy)
                begin
                    $error("hit_y expected %0d actual %0d", e.hy, ay);
                    errors++;
                end
                if (m_axis_tdata[73:48] !== e.distance)
                begin
                    $error("hit_distance expected %0d actual %0d", e.distance,
                           m_axis_tdata[73:48]);
                    errors++;
                end
                if (m_axis_tdata[81:74] !== e.tag)
                begin
                    $error("hit_wall_tag expected %0d actual %0d", e.tag,
                           m_axis_tdata[81:74]);
                    errors++;
                end
            end
        end
    end

    // A fresh wait is drawn after every beat taken.
    always @(negedge clk)
    begin
        int gap;
        gap = m_taken_q ? int'($urandom_range(0, 4)) : recv_wait;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            recv_wait <= gap;
            m_axis_tready <= 1'b0;
        end
        else if (gap > 0)
        begin
            recv_wait <= gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            recv_wait <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic signed [23:0] rnd_pt(int span);
        return 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic add_beat(input logic signed [18:0] rx, ry,
                            input logic signed [23:0] ox, oy, x1, y1, x2, y2,
                            input logic kind, input logic [7:0] tag, input logic last);
        wall_beat_t w;
        w.ray_x = rx; w.ray_y = ry; w.org_x = ox; w.org_y = oy;
        w.x1 = x1; w.y1 = y1; w.x2 = x2; w.y2 = y2;
        w.kind = kind; w.tag = tag; w.last = last;
        pending_beats.push_back(w);
    endtask

    // One ray against one to five random walls, mostly with their ends in order.
    task automatic add_ray(input int span);
        logic signed [18:0] rx, ry;
        logic signed [23:0] ox, oy, a, lo, hi;
        int n;
        rx = ($urandom_range(0, 9) == 0) ? 19'sd0 : 19'($urandom);
        ry = ($urandom_range(0, 9) == 0) ? 19'sd0 : 19'($urandom);
        ox = rnd_pt(span);
        oy = rnd_pt(span);
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            a = rnd_pt(span);
            lo = rnd_pt(span);
            hi = ($urandom_range(0, 7) == 0) ? rnd_pt(span)
                                             : 24'(lo + $urandom_range(0, 2 * span));
            if ($urandom_range(0, 1))
                add_beat(rx, ry, ox, oy, lo, a, hi, a + 24'sd1, 1'b1, 8'($urandom),
                         i == n - 1);
            else
                add_beat(rx, ry, ox, oy, a, lo, a + 24'sd1, hi, 1'b0, 8'($urandom),
                         i == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_limit(input logic [25:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lim = v;
        clear_nearest();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clear_nearest();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, parallel rays, rays pointing away, head-on walls, reversed ends.
        add_beat(19'sd0, 19'sd65536, 24'sd0, 24'sd0, -24'sd8388608, 24'sd65536,
                 24'sd8388607, 24'sd65536, 1'b1, 8'd1, 1'b1);
        add_beat(19'sd65536, 19'sd0, 24'sd0, 24'sd0, 24'sd65536, -24'sd100, 24'sd65536,
                 24'sd100, 1'b1, 8'd2, 1'b1);
        add_beat(19'sd65536, 19'sd0, 24'sd0, 24'sd0, 24'sd65536, -24'sd100, 24'sd65536,
                 24'sd100, 1'b0, 8'd3, 1'b1);
        add_beat(19'sd65536, 19'sd65536, 24'sd0, 24'sd0, -24'sd65536, -24'sd9,
                 -24'sd65536, 24'sd9, 1'b0, 8'd4, 1'b1);
        add_beat(-19'sd262144, 19'sd262143, 24'sd8388607, -24'sd8388608,
                 -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607, 1'b0, 8'd255,
                 1'b0);
        add_beat(-19'sd262144, 19'sd262143, 24'sd8388607, -24'sd8388608,
                 -24'sd8388608, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b1, 8'd0,
                 1'b1);
        add_beat(19'sd1, -19'sd262144, 24'sd0, 24'sd0, 24'sd100, -24'sd65536, -24'sd100,
                 -24'sd65536, 1'b1, 8'd7, 1'b1);
        add_beat(19'sd65536, 19'sd65536, 24'sd0, 24'sd0, 24'sd131072, -24'sd300000,
                 24'sd131072, 24'sd300000, 1'b0, 8'd8, 1'b0);
        add_beat(19'sd65536, 19'sd65536, 24'sd0, 24'sd0, 24'sd131072, -24'sd300000,
                 24'sd131072, 24'sd300000, 1'b0, 8'd9, 1'b1);
        drain();

        write_limit(26'h3FFFFFF);
        hold_off = 300;
        for (int i = 0; i < 60; i++) add_ray(8388607);
        drain();
        write_limit(26'd0);
        for (int i = 0; i < 20; i++) add_ray(400000);
        drain();
        write_limit(26'd200000);
        for (int i = 0; i < 90; i++) add_ray(300000);
        drain();
        write_limit(26'(LIMIT_BASE << FRAC_BITS_DEF));
        for (int i = 0; i < 130; i++) add_ray($urandom_range(0, 3) == 0 ? 8388607 : 600000);
        drain();

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rwnh_pkg.sv
hw/rtl/rwnh_div.sv
hw/rtl/rwnh_sqrt.sv
hw/rtl/ray_axis_wall_nearest_hit.sv
tb/testbench.sv
